// ===== hdl/usr7_pkg.sv =====
// shared types and constants for the sysex7 packet reassembler
// used by the top level, the byte unit and the checker; no dependencies

package usr7_pkg;

   // universal packet fields
   localparam logic [3:0] TYPE_SYSEX7 = 4'h3;

   // sysex7 status codes
   localparam logic [3:0] ST_COMPLETE = 4'h0;
   localparam logic [3:0] ST_START    = 4'h1;
   localparam logic [3:0] ST_CONTINUE = 4'h2;
   localparam logic [3:0] ST_END      = 4'h3;

   // midi 1.0 framing bytes
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;

   // result kinds
   localparam logic [1:0] KIND_DATA       = 2'd0;
   localparam logic [1:0] KIND_NO_START   = 2'd1;
   localparam logic [1:0] KIND_BAD_STATUS = 2'd2;

   // payload window: packet byte positions 2..7
   localparam int PAYLOAD_BYTES = 6;
   localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;

   // control from the sequencer to the byte unit
   typedef struct packed {
      logic load;
      logic shift;
   } usr7_ctl_type;

   // status from the byte unit back to the sequencer
   typedef struct packed {
      logic more;
      logic last;
   } usr7_sts_type;

endpackage

// ===== hdl/usr7_byte_unit.sv =====
// payload byte unit: shift register over the packet payload and a byte counter
// depends on usr7_pkg

module usr7_byte_unit #(
   parameter int MAX_BYTES = 6
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  usr7_pkg::usr7_ctl_type                   ctl,
   input  logic [usr7_pkg::PAYLOAD_W-1:0]           load_data,
   input  logic [$clog2(MAX_BYTES+1)-1:0]           load_count,
   output usr7_pkg::usr7_sts_type                   sts,
   output logic [7:0]                               byte_out
);
   import usr7_pkg::*;

   localparam int CNT_W = $clog2(MAX_BYTES + 1);

   logic [PAYLOAD_W-1:0] data_ff, data_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // load a new payload or move the next byte to the top
   always_comb begin
      data_in  = data_ff;
      count_in = count_ff;
      if (ctl.load) begin
         data_in  = load_data;
         count_in = load_count;
      end else if (ctl.shift) begin
         data_in  = {data_ff[PAYLOAD_W-9:0], 8'h00};
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign byte_out = data_ff[PAYLOAD_W-1 -: 8];
   assign sts.more = (count_ff != '0);
   assign sts.last = (count_ff == CNT_W'(1));

endmodule

// ===== hdl/ump_sysex7_reassembler.sv =====
// top level of the sysex7 packet to midi 1.0 sysex byte stream reassembler
// depends on usr7_pkg and usr7_byte_unit

// Takes one 64-bit SysEx7 packet per item and streams MIDI 1.0 SysEx bytes,
// one result per cycle within a packet while the result side is ready: F0 for
// complete and start packets, up to MAX_PAYLOAD_BYTES payload bytes, then F7
// for complete and end packets. Packets of other message types are dropped in
// the cycle they are taken. A SysEx7 packet is accepted first; then the byte
// sequencer feeds the output register one result at a time and waits while
// the result side stalls. req_ready is high only while the sequencer is idle;
// the next packet may be taken while the last result of the previous one
// waits in the output register. Continue or end packets with no open message,
// and unknown status codes, give one error result with a zero byte.

module ump_sysex7_reassembler #(
   parameter int MAX_PAYLOAD_BYTES = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_packet_word_hi,
   input  logic [31:0] req_packet_word_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_result_kind,
   output logic        rsp_message_done,
   output logic        rsp_run_last
);
   import usr7_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HEAD = 3'd1;
   localparam logic [2:0] S_DATA = 3'd2;
   localparam logic [2:0] S_TAIL = 3'd3;
   localparam logic [2:0] S_ERR  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       open_ff, open_in;
   logic       tail_ff, tail_in;
   logic [1:0] err_kind_ff, err_kind_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [1:0] kind_ff, kind_in;
   logic       done_ff, done_in;
   logic       last_ff, last_in;

   logic [3:0]       pkt_type, pkt_status, raw_count;
   logic [CNT_W-1:0] capped_count;
   logic             has_data;
   logic [2:0]       start_state;
   logic             dec_tail, dec_open;
   logic [1:0]       dec_err_kind;

   logic accept, slot_free, step;

   usr7_ctl_type ctl;
   usr7_sts_type sts;
   logic [7:0]   unit_byte;

   // packet fields and byte count cap
   assign pkt_type   = req_packet_word_hi[31:28];
   assign pkt_status = req_packet_word_hi[23:20];
   assign raw_count  = req_packet_word_hi[19:16];
   assign capped_count = (raw_count > 4'(MAX_PAYLOAD_BYTES)) ?
                         CNT_W'(MAX_PAYLOAD_BYTES) : CNT_W'(raw_count);
   assign has_data = (capped_count != '0);

   // decode the packet into a result plan
   always_comb begin
      start_state  = S_IDLE;
      dec_tail     = 1'b0;
      dec_open     = open_ff;
      dec_err_kind = KIND_BAD_STATUS;
      if (pkt_type == TYPE_SYSEX7) begin
         case (pkt_status)
            ST_COMPLETE: begin
               start_state = S_HEAD;
               dec_tail    = 1'b1;
               dec_open    = 1'b0;
            end
            ST_START: begin
               start_state = S_HEAD;
               dec_open    = 1'b1;
            end
            ST_CONTINUE: begin
               if (!open_ff) begin
                  start_state  = S_ERR;
                  dec_err_kind = KIND_NO_START;
               end else if (has_data) begin
                  start_state = S_DATA;
               end
            end
            ST_END: begin
               if (!open_ff) begin
                  start_state  = S_ERR;
                  dec_err_kind = KIND_NO_START;
               end else begin
                  start_state = has_data ? S_DATA : S_TAIL;
                  dec_tail    = 1'b1;
                  dec_open    = 1'b0;
               end
            end
            default: begin
               start_state  = S_ERR;
               dec_err_kind = KIND_BAD_STATUS;
            end
         endcase
      end
   end

   // handshakes
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign step      = (state_ff != S_IDLE) && slot_free;

   assign ctl.load  = accept;
   assign ctl.shift = step && (state_ff == S_DATA);

   usr7_byte_unit #(
      .MAX_BYTES (MAX_PAYLOAD_BYTES)
   ) u_byte_unit (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .load_data  ({req_packet_word_hi[15:0], req_packet_word_lo}),
      .load_count (capped_count),
      .sts        (sts),
      .byte_out   (unit_byte)
   );

   // sequencer: one result into the output register per step
   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      tail_in      = tail_ff;
      err_kind_in  = err_kind_ff;
      out_byte_in  = out_byte_ff;
      kind_in      = kind_ff;
      done_in      = done_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         state_in    = start_state;
         open_in     = dec_open;
         tail_in     = dec_tail;
         err_kind_in = dec_err_kind;
      end else if (step) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_DATA;
         done_in      = 1'b0;
         case (state_ff)
            S_HEAD: begin
               out_byte_in = SYSEX_START;
               last_in     = !sts.more && !tail_ff;
               state_in    = sts.more ? S_DATA : (tail_ff ? S_TAIL : S_IDLE);
            end
            S_DATA: begin
               out_byte_in = unit_byte;
               last_in     = sts.last && !tail_ff;
               if (sts.last) begin
                  state_in = tail_ff ? S_TAIL : S_IDLE;
               end
            end
            S_TAIL: begin
               out_byte_in = SYSEX_END;
               done_in     = 1'b1;
               last_in     = 1'b1;
               state_in    = S_IDLE;
            end
            S_ERR: begin
               out_byte_in = 8'h00;
               kind_in     = err_kind_ff;
               last_in     = 1'b1;
               state_in    = S_IDLE;
            end
            default: begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // plan and result payload registers
   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      err_kind_ff <= err_kind_in;
      out_byte_ff <= out_byte_in;
      kind_ff     <= kind_in;
      done_ff     <= done_in;
      last_ff     <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_message_done = done_ff;
   assign rsp_run_last     = last_ff;

endmodule

// ===== hdl/usr7_checker.sv =====
// port-level checks for the sysex7 reassembler, bound to the top level
// depends on usr7_pkg and ump_sysex7_reassembler

module usr7_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [31:0] req_packet_word_hi,
   input logic [31:0] req_packet_word_lo,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic [1:0]  rsp_result_kind,
   input logic        rsp_message_done,
   input logic        rsp_run_last
);
   import usr7_pkg::*;

   // a waiting packet holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_packet_word_hi)
         && $stable(req_packet_word_lo))
      else $error("waiting packet changed");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_result_kind) && $stable(rsp_run_last))
      else $error("stalled result changed");

   // closing item is an F7 data byte
   a_done_f7: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_done |->
         rsp_out_byte == SYSEX_END && rsp_result_kind == KIND_DATA && rsp_run_last)
      else $error("message_done on a non-F7 item");

   // error items are zero, last and never message_done
   a_err_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_DATA |->
         rsp_run_last && rsp_out_byte == 8'h00 && !rsp_message_done)
      else $error("malformed error item");

   // no new packet while results of the current one are still pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> !req_ready)
      else $error("packet taken mid-sequence");

endmodule

bind ump_sysex7_reassembler usr7_checker u_usr7_checker (.*);

// ===== test/usr7_stream_checker.sv =====
// checker for the sysex7 reassembler: watches both channels and predicts the byte stream
// depends on usr7_pkg; instantiated beside the block by tb_ump_sysex7_reassembler

module usr7_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_packet_word_hi,
   input  logic [31:0] req_packet_word_lo,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic [1:0]  rsp_result_kind,
   input  logic        rsp_message_done,
   input  logic        rsp_run_last,
   output int          mismatches,
   output int          outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   import usr7_pkg::*;

   // one predicted result item
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       done;
      logic       last;
   } sysex_byte_type;

   sysex_byte_type sysex_bytes_q[$];
   logic           msg_open;
   int             errors;

   assign mismatches  = errors;
   assign outstanding = sysex_bytes_q.size();

   initial begin
      errors   = 0;
      msg_open = 1'b0;
   end

   function automatic void push_byte(input logic [7:0] data, input logic [1:0] kind,
                                     input logic done);
      sysex_byte_type b;
      b.data = data;
      b.kind = kind;
      b.done = done;
      b.last = 1'b0;
      sysex_bytes_q = {sysex_bytes_q, b};
   endfunction

   function automatic void push_payload(input logic [63:0] pkt, input int n);
      for (int i = 0; i < n; i++)
         push_byte(pkt[63 - 8 * (2 + i) -: 8], KIND_DATA, 1'b0);
   endfunction

   // expand one accepted packet into its expected byte stream
   function automatic void expand_packet(input logic [31:0] hi, input logic [31:0] lo);
      logic [63:0] pkt;
      logic [3:0]  status;
      int          n;
      int          first;
      pkt    = {hi, lo};
      status = hi[23:20];
      n      = (hi[19:16] > PAYLOAD_BYTES) ? PAYLOAD_BYTES : int'(hi[19:16]);
      first  = sysex_bytes_q.size();
      if (hi[31:28] != TYPE_SYSEX7)
         return;
      case (status)
         ST_COMPLETE, ST_START: begin
            push_byte(SYSEX_START, KIND_DATA, 1'b0);
            push_payload(pkt, n);
            if (status == ST_COMPLETE) begin
               push_byte(SYSEX_END, KIND_DATA, 1'b1);
               msg_open = 1'b0;
            end else begin
               msg_open = 1'b1;
            end
         end
         ST_CONTINUE, ST_END: begin
            if (!msg_open) begin
               push_byte(8'h00, KIND_NO_START, 1'b0);
            end else begin
               push_payload(pkt, n);
               if (status == ST_END) begin
                  push_byte(SYSEX_END, KIND_DATA, 1'b1);
                  msg_open = 1'b0;
               end
            end
         end
         default: push_byte(8'h00, KIND_BAD_STATUS, 1'b0);
      endcase
      if (sysex_bytes_q.size() > first)
         sysex_bytes_q[$].last = 1'b1;
   endfunction

   // compare accepted results, then predict from accepted packets
   always @(posedge clock) begin
      sysex_byte_type exp_b;
      if (reset) begin
         sysex_bytes_q.delete();
         msg_open = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sysex_bytes_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result item: byte %h kind %0d done %0b last %0b",
                        $time, rsp_out_byte, rsp_result_kind, rsp_message_done,
                        rsp_run_last);
            end else begin
               exp_b = sysex_bytes_q.pop_front();
               if (rsp_out_byte !== exp_b.data) begin
                  errors++;
                  $display("%0t: out_byte expected %h actual %h",
                           $time, exp_b.data, rsp_out_byte);
               end
               if (rsp_result_kind !== exp_b.kind) begin
                  errors++;
                  $display("%0t: result_kind expected %0d actual %0d",
                           $time, exp_b.kind, rsp_result_kind);
               end
               if (rsp_message_done !== exp_b.done) begin
                  errors++;
                  $display("%0t: message_done expected %0b actual %0b",
                           $time, exp_b.done, rsp_message_done);
               end
               if (rsp_run_last !== exp_b.last) begin
                  errors++;
                  $display("%0t: run_last expected %0b actual %0b",
                           $time, exp_b.last, rsp_run_last);
               end
            end
         end
         if (req_valid && req_ready)
            expand_packet(req_packet_word_hi, req_packet_word_lo);
      end
   end

endmodule

// ===== test/tb_ump_sysex7_reassembler.sv =====
// testbench top for the sysex7 reassembler: clock, reset, packet stimulus and verdict
// depends on usr7_pkg, ump_sysex7_reassembler and usr7_stream_checker

module tb_ump_sysex7_reassembler;

   timeunit 1ns;
   timeprecision 1ps;

   import usr7_pkg::*;

   // message types other than sysex7, used as noise
   localparam logic [3:0] TYPE_UTILITY  = 4'h0;
   localparam logic [3:0] TYPE_RESERVED = 4'hF;
   localparam logic [3:0] ST_FIRST_BAD  = ST_END + 4'd1;
   localparam int         RANDOM_ITEMS  = 200;
   localparam int         HOLD_AT_ITEM  = 40;
   localparam int         HOLD_CYCLES   = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_packet_word_hi = '0;
   logic [31:0] req_packet_word_lo = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_result_kind;
   logic        rsp_message_done;
   logic        rsp_run_last;
   int          mismatches;
   int          outstanding;
   logic        tx_burst = 1'b0;
   logic        rx_burst = 1'b0;

   ump_sysex7_reassembler #(.MAX_PAYLOAD_BYTES(PAYLOAD_BYTES)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_packet_word_hi(req_packet_word_hi),
      .req_packet_word_lo(req_packet_word_lo),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_message_done (rsp_message_done),
      .rsp_run_last     (rsp_run_last)
   );

   usr7_stream_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_packet_word_hi(req_packet_word_hi),
      .req_packet_word_lo(req_packet_word_lo),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_message_done (rsp_message_done),
      .rsp_run_last     (rsp_run_last),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [31:0] pack_hi(input logic [3:0] mtype, input logic [3:0] group,
                                           input logic [3:0] status, input logic [3:0] count,
                                           input logic [15:0] data);
      return {mtype, group, status, count, data};
   endfunction

   // mostly legal counts, sometimes above the cap
   function automatic logic [3:0] pick_count();
      if ($urandom_range(0, 9) == 0)
         return 4'($urandom_range(PAYLOAD_BYTES + 1, 15));
      return 4'($urandom_range(0, PAYLOAD_BYTES));
   endfunction

   // offer one packet after a random gap and wait for it to be taken
   task automatic send_packet(input logic [31:0] hi, input logic [31:0] lo);
      int unsigned gap;
      gap = tx_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_packet_word_hi <= hi;
      req_packet_word_lo <= lo;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sysex7 packet with random group and payload
   task automatic send_sysex(input logic [3:0] status, input logic [3:0] count);
      send_packet(pack_hi(TYPE_SYSEX7, 4'($urandom), status, count, 16'($urandom)),
                  $urandom);
   endtask

   // receiver: random stalls per item, one long hold-off to back up the block
   initial begin
      int unsigned n;
      int          taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 16 == 0)
            rx_burst = ($urandom_range(0, 3) == 0);
         if (taken == HOLD_AT_ITEM)
            n = HOLD_CYCLES;
         else
            n = rx_burst ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   // stimulus and verdict
   initial begin
      int          items;
      int unsigned pick;
      int unsigned parts;
      logic [3:0]  mtype;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored types, extremes, orphans, bad status, abandon, cap
      send_packet(pack_hi(TYPE_UTILITY, 4'hF, ST_COMPLETE, 4'h6, 16'hFFFF), 32'hFFFF_FFFF);
      send_packet(pack_hi(TYPE_RESERVED, 4'hF, ST_START, 4'h6, 16'h1234), 32'h5678_9ABC);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h0, ST_COMPLETE, 4'h0, 16'h0000), 32'h0000_0000);
      send_packet(pack_hi(TYPE_SYSEX7, 4'hF, ST_COMPLETE, 4'h6, 16'hFFFF), 32'hFFFF_FFFF);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h5, ST_COMPLETE, 4'hF, 16'hA55A), 32'h5AA5_C33C);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h1, ST_CONTINUE, 4'h3, 16'h0102), 32'h0304_0506);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h2, ST_END, 4'h6, 16'h1112), 32'h1314_1516);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h3, ST_FIRST_BAD, 4'h2, 16'h2122), 32'h2324_2526);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h4, 4'hF, 4'hF, 16'hFFFF), 32'hFFFF_FFFF);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h0, ST_START, 4'h2, 16'h4142), 32'h4344_4546);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h0, ST_CONTINUE, 4'h0, 16'h5152), 32'h5354_5556);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h0, ST_CONTINUE, 4'h6, 16'h6162), 32'h6364_6566);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h0, 4'h8, 4'h1, 16'h7172), 32'h7374_7576);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h0, ST_START, 4'h1, 16'h8182), 32'h8384_8586);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h0, ST_END, 4'h0, 16'h9192), 32'h9394_9596);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h7, ST_START, 4'h6, 16'hA1A2), 32'hA3A4_A5A6);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h7, ST_END, 4'h9, 16'hB1B2), 32'hB3B4_B5B6);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h0, ST_COMPLETE, 4'h1, 16'h0000), 32'h0000_0000);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h8, ST_START, 4'h0, 16'hC1C2), 32'hC3C4_C5C6);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h8, ST_COMPLETE, 4'h3, 16'hD1D2), 32'hD3D4_D5D6);
      send_packet(pack_hi(TYPE_SYSEX7, 4'h8, ST_END, 4'h2, 16'hE1E2), 32'hE3E4_E5E6);

      // random: mostly well-formed messages, some noise and broken messages
      items = 0;
      while (items < RANDOM_ITEMS) begin
         tx_burst = ($urandom_range(0, 4) == 0);
         pick     = $urandom_range(0, 99);
         if (pick < 55) begin
            parts = $urandom_range(0, 4);
            send_sysex(ST_START, pick_count());
            repeat (parts) send_sysex(ST_CONTINUE, pick_count());
            send_sysex(ST_END, pick_count());
            items += parts + 2;
         end else if (pick < 72) begin
            send_sysex(ST_COMPLETE, pick_count());
            items++;
         end else if (pick < 82) begin
            // other message types are dropped and not counted
            mtype = 4'($urandom_range(0, 15));
            if (mtype == TYPE_SYSEX7)
               mtype = TYPE_RESERVED;
            send_packet(pack_hi(mtype, 4'($urandom), 4'($urandom), 4'($urandom),
                                16'($urandom)), $urandom);
         end else if (pick < 90) begin
            // start left open, then continued or abandoned
            parts = $urandom_range(0, 2);
            send_sysex(ST_START, pick_count());
            repeat (parts) send_sysex(ST_CONTINUE, pick_count());
            items += parts + 1;
         end else if (pick < 95) begin
            send_sysex(($urandom_range(0, 1) == 0) ? ST_CONTINUE : ST_END, pick_count());
            items++;
         end else begin
            send_sysex(4'($urandom_range(ST_FIRST_BAD, 15)), 4'($urandom));
            items++;
         end
      end
      req_valid <= 1'b0;

      // drain and let the tail settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/usr7_pkg.sv
hdl/usr7_byte_unit.sv
hdl/ump_sysex7_reassembler.sv
hdl/usr7_checker.sv
test/usr7_stream_checker.sv
test/tb_ump_sysex7_reassembler.sv
